/* sv/fdd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fdd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOPE_W    = 32;
    localparam int SUM_W      = 32;
    localparam int MAG_W      = SUM_W - 1;
    localparam int PROD_W     = MAG_W + CFG_W;

    // Record length limit
    localparam int MAX_RECORD = 65535;
    localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(MAX_RECORD - 1);

    // Register reset values
    localparam logic [CFG_W-1:0] INV_STEP_RESET    = 24'd65536;
    localparam logic [CFG_W-1:0] INV_TWELVE_RESET  = 24'd5461;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_STEP        = 1'b0,
        CFG_INV_TWELVE_STEP = 1'b1
    } cfg_index_t;

    // Which stencil pair a result uses
    typedef enum logic [2:0] {
        K_HEAD0,
        K_HEAD1,
        K_CENTER,
        K_TAIL1,
        K_TAIL2,
        K_SHORT
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MUL2,
        ST_MUL4,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  accept;
        logic  load_sums;
        kind_t kind;
        logic  mul_second;
        logic  mul_fourth;
        logic  load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic lt4;
        logic eq4;
        logic is_final;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* sv/fdd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fdd_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic signed [fdd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                           last_sample,
    input  wire logic                           cfg_valid,
    input  wire logic [fdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fdd_pkg::CFG_W-1:0]      cfg_data,
    input  wire fdd_pkg::dp_cmd_t               cmd,
    output fdd_pkg::dp_stat_t                   stat,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [fdd_pkg::COUNT_W-1:0]         position,
    output logic signed [fdd_pkg::SLOPE_W-1:0]  second_order_slope,
    output logic signed [fdd_pkg::SLOPE_W-1:0]  fourth_order_slope,
    output logic                                clipped,
    output logic                                too_short,
    output logic                                last_result
);
    import fdd_pkg::*;

    typedef struct packed {
        logic               clip;
        logic [SLOPE_W-1:0] value;
    } sat_t;

    // Round to nearest (ties away from zero), shift by 16 or 17, saturate
    function automatic sat_t round_sat(input logic [PROD_W-1:0] prod, input logic neg,
                                       input logic sh17);
        logic [PROD_W:0]   rsum;
        logic [PROD_W-16:0] r;
        sat_t              res;
        rsum = {1'b0, prod} + (sh17 ? (PROD_W+1)'(32'h10000) : (PROD_W+1)'(32'h8000));
        r = sh17 ? {1'b0, rsum[PROD_W:17]} : rsum[PROD_W:16];
        res.clip = 1'b0;
        if (!neg) begin
            if (r > (PROD_W-15)'(32'h7FFF_FFFF)) begin
                res.clip  = 1'b1;
                res.value = 32'h7FFF_FFFF;
            end else begin
                res.value = r[SLOPE_W-1:0];
            end
        end else begin
            if (r > (PROD_W-15)'(32'h8000_0000)) begin
                res.clip  = 1'b1;
                res.value = 32'h8000_0000;
            end else begin
                res.value = SLOPE_W'(0) - r[SLOPE_W-1:0];
            end
        end
        return res;
    endfunction

    logic [CFG_W-1:0]           inv_step_reg;
    logic [CFG_W-1:0]           inv_twelve_reg;
    logic signed [SAMPLE_W-1:0] win_reg [5];
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         idx_reg;

    logic signed [SUM_W-1:0]    w0, w1, w2, w3, w4;
    logic signed [SUM_W-1:0]    s2, s4, s2_neg, s4_neg;
    logic [COUNT_W-1:0]         pos_next;
    logic                       sh17_next;
    logic                       last_next;
    logic                       short_next;

    logic                       neg2_reg, neg4_reg, sh17_reg, last_reg, short_reg;
    logic [MAG_W-1:0]           mag2_reg, mag4_reg;
    logic [COUNT_W-1:0]         pos_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [SLOPE_W-1:0]         slope2_reg;
    logic                       clip2_reg;
    sat_t                       sat2, sat4;

    logic                       out_valid_reg;
    logic [COUNT_W-1:0]         position_reg;
    logic [SLOPE_W-1:0]         second_reg, fourth_reg;
    logic                       clipped_reg, too_short_reg, last_result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_step_reg   <= INV_STEP_RESET;
            inv_twelve_reg <= INV_TWELVE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INV_STEP:        inv_step_reg   <= cfg_data;
                CFG_INV_TWELVE_STEP: inv_twelve_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample window and record position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                win_reg[i] <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            for (int i = 0; i < 4; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[4] <= sample;
            idx_reg    <= count_reg;
            count_reg  <= stat.is_final ? '0 : count_reg + COUNT_W'(1);
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.lt4      = count_reg < COUNT_W'(4);
        stat.eq4      = count_reg == COUNT_W'(4);
        stat.is_final = last_sample || (count_reg == LAST_INDEX);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    // Stencil sums for the selected result
    always_comb
    begin
        w0 = SUM_W'(win_reg[0]);
        w1 = SUM_W'(win_reg[1]);
        w2 = SUM_W'(win_reg[2]);
        w3 = SUM_W'(win_reg[3]);
        w4 = SUM_W'(win_reg[4]);
        s2         = '0;
        s4         = '0;
        sh17_next  = 1'b1;
        last_next  = 1'b0;
        short_next = 1'b0;
        pos_next   = idx_reg;
        unique case (cmd.kind)
            K_HEAD0:
            begin
                s2 = w1 - w0;
                s4 = -32'sd25 * w0 + 32'sd48 * w1 - 32'sd36 * w2 + 32'sd16 * w3 - 32'sd3 * w4;
                sh17_next = 1'b0;
                pos_next  = '0;
            end
            K_HEAD1:
            begin
                s2 = w2 - w0;
                s4 = -32'sd3 * w0 - 32'sd10 * w1 + 32'sd18 * w2 - 32'sd6 * w3 + w4;
                pos_next = COUNT_W'(1);
            end
            K_CENTER:
            begin
                s2 = w3 - w1;
                s4 = w0 - 32'sd8 * w1 + 32'sd8 * w3 - w4;
                pos_next = idx_reg - COUNT_W'(2);
            end
            K_TAIL1:
            begin
                s2 = w4 - w2;
                s4 = 32'sd3 * w4 + 32'sd10 * w3 - 32'sd18 * w2 + 32'sd6 * w1 - w0;
                pos_next = idx_reg - COUNT_W'(1);
            end
            K_TAIL2:
            begin
                s2 = w4 - w3;
                s4 = 32'sd25 * w4 - 32'sd48 * w3 + 32'sd36 * w2 - 32'sd16 * w1 + 32'sd3 * w0;
                sh17_next = 1'b0;
                last_next = 1'b1;
            end
            K_SHORT:
            begin
                last_next  = 1'b1;
                short_next = 1'b1;
            end
            default: ;
        endcase
        s2_neg = -s2;
        s4_neg = -s4;
    end

    // Sign and magnitude of the sums
    always_ff @(posedge clk)
    begin
        if (cmd.load_sums)
        begin
            neg2_reg  <= s2[SUM_W-1];
            neg4_reg  <= s4[SUM_W-1];
            mag2_reg  <= s2[SUM_W-1] ? s2_neg[MAG_W-1:0] : s2[MAG_W-1:0];
            mag4_reg  <= s4[SUM_W-1] ? s4_neg[MAG_W-1:0] : s4[MAG_W-1:0];
            sh17_reg  <= sh17_next;
            last_reg  <= last_next;
            short_reg <= short_next;
            pos_reg   <= pos_next;
        end
    end

    // Shared multiplier: second-order product, then fourth-order product
    always_ff @(posedge clk)
    begin
        if (cmd.mul_second)
            prod_reg <= PROD_W'(mag2_reg) * PROD_W'(inv_step_reg);
        else if (cmd.mul_fourth)
            prod_reg <= PROD_W'(mag4_reg) * PROD_W'(inv_twelve_reg);
    end

    assign sat2 = round_sat(prod_reg, neg2_reg, sh17_reg);
    assign sat4 = round_sat(prod_reg, neg4_reg, 1'b0);

    // Hold the scaled second-order slope while the fourth-order product forms
    always_ff @(posedge clk)
    begin
        if (cmd.mul_fourth)
        begin
            slope2_reg <= sat2.value;
            clip2_reg  <= sat2.clip;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            position_reg    <= pos_reg;
            second_reg      <= slope2_reg;
            fourth_reg      <= sat4.value;
            clipped_reg     <= clip2_reg || sat4.clip;
            too_short_reg   <= short_reg;
            last_result_reg <= last_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign position           = position_reg;
    assign second_order_slope = second_reg;
    assign fourth_order_slope = fourth_reg;
    assign clipped            = clipped_reg;
    assign too_short          = too_short_reg;
    assign last_result        = last_result_reg;

`ifndef ASSERT_OFF
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && too_short_reg |-> last_result_reg)
        else $error("too_short result not marked last");

    a_short_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && too_short_reg |-> !clipped_reg)
        else $error("too_short result flagged as clipped");
`endif

endmodule

`default_nettype wire

/* sv/fdd_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

module fdd_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fdd_pkg::dp_stat_t stat,
    output fdd_pkg::dp_cmd_t       cmd
);
    import fdd_pkg::*;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   final_reg, final_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_CENTER;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            final_reg <= final_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    final_next = stat.is_final;
                    if (stat.lt4)
                    begin
                        if (stat.is_final)
                        begin
                            kind_next  = K_SHORT;
                            state_next = ST_SUMS;
                        end
                    end
                    else if (stat.eq4)
                    begin
                        kind_next  = K_HEAD0;
                        state_next = ST_SUMS;
                    end
                    else
                    begin
                        kind_next  = K_CENTER;
                        state_next = ST_SUMS;
                    end
                end
            end
            ST_SUMS:
            begin
                cmd.load_sums = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = ST_MUL4;
            end
            ST_MUL4:
            begin
                cmd.mul_fourth = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_SUMS;
                    unique case (kind_reg)
                        K_HEAD0: kind_next = K_HEAD1;
                        K_HEAD1: kind_next = K_CENTER;
                        K_CENTER:
                        begin
                            if (final_reg)
                                kind_next = K_TAIL1;
                            else
                                state_next = ST_IDLE;
                        end
                        K_TAIL1: kind_next = K_TAIL2;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output loaded over an unaccepted beat");

    a_tail_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && (kind_reg == K_TAIL1 || kind_reg == K_TAIL2) |-> final_reg)
        else $error("tail stencil on a record that is not ending");

    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL2 |=> state_reg == ST_MUL4)
        else $error("fourth-order product skipped");
`endif

endmodule

`default_nettype wire

/* sv/finite_difference_differentiator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming first-derivative estimator over records of uniformly spaced samples.
// Input channel (in_valid/in_stall) carries sample and last_sample; a beat is
// taken when in_valid is high and in_stall low. Output channel (out_valid/out_stall)
// carries one derivative result per beat; configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) set inv_step and inv_twelve_step and should only be issued
// while the block is idle.
// Results are computed one at a time by a shared 31x24 multiplier; a sample
// yields r results (r is 0, 1, 3 or 5). For each result the sums, the
// second-order product and the fourth-order product are registered in turn,
// then the result is loaded into the output register once that is free.
// Results lag input by two samples: the fifth sample of a record yields positions
// 0..2, the final sample also flushes the last two; records under five samples
// give a single too_short result.
// A finished result waits in the output register while the receiver stalls; the
// next result is held back until that beat is taken, and a new sample is accepted
// as soon as the last result of the previous one is loaded.
// Reset clears the window, the sample count and the output valid, and restores
// both step registers to their defaults.

module finite_difference_differentiator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [fdd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                last_sample,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fdd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [fdd_pkg::CFG_W-1:0]           cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [fdd_pkg::COUNT_W-1:0]              position,
    output logic signed [fdd_pkg::SLOPE_W-1:0]       second_order_slope,
    output logic signed [fdd_pkg::SLOPE_W-1:0]       fourth_order_slope,
    output logic                                     clipped,
    output logic                                     too_short,
    output logic                                     last_result
);
    import fdd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Step registers take a write in any cycle
    assign cfg_ready = 1'b1;

    fdd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fdd_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample             (sample),
        .last_sample        (last_sample),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .stat               (stat),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .position           (position),
        .second_order_slope (second_order_slope),
        .fourth_order_slope (fourth_order_slope),
        .clipped            (clipped),
        .too_short          (too_short),
        .last_result        (last_result)
    );

endmodule

`default_nettype wire
